/* rtl/amgt_pkg.sv */
// Shared types and constants for the adjacency-matrix graph traversal block.
package amgt_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int DATA_WIDTH_DEF   = 32;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int VCOUNT_W   = 5;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RST = 5'd16;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VCOUNT = 1'b1;

  localparam logic MODE_BFS = 1'b0;
  localparam logic MODE_DFS = 1'b1;

  typedef enum logic [1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_ADD_EDGE = 2'd1,
    CMD_SET_DATA = 2'd2,
    CMD_RUN      = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_RDA,
    ST_EDGE_WRA,
    ST_EDGE_RDB,
    ST_EDGE_WRB,
    ST_RUN_NEXT,
    ST_POP,
    ST_FETCH,
    ST_EMIT,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic clear;
    logic row_we;
    logic data_we;
  } store_ctl_t;

endpackage

/* rtl/amgt_in_if.sv */
// Input item channel: command, vertex pair and data word.
interface amgt_in_if #(
  parameter int VW = 4,
  parameter int DW = 32
) ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           cmd;
  logic [VW-1:0]        first_vertex;
  logic [VW-1:0]        second_vertex;
  logic signed [DW-1:0] vertex_value;

  modport source (
    output valid, cmd, first_vertex, second_vertex, vertex_value,
    input  ready
  );
  modport sink (
    input  valid, cmd, first_vertex, second_vertex, vertex_value,
    output ready
  );
endinterface

/* rtl/amgt_out_if.sv */
// Result item channel: visited vertex, its data word and the last flag.
interface amgt_out_if #(
  parameter int VW = 4,
  parameter int DW = 32
) ();
  logic                 valid;
  logic                 ready;
  logic [VW-1:0]        visited_vertex;
  logic signed [DW-1:0] visited_value;
  logic                 last_visit;

  modport source (
    output valid, visited_vertex, visited_value, last_visit,
    input  ready
  );
  modport sink (
    input  valid, visited_vertex, visited_value, last_visit,
    output ready
  );
endinterface

/* rtl/adjacency_matrix_graph_traversal_top.sv */
// Undirected graph store with breadth-first or depth-first traversal. Add edge reads
// and rewrites the row of each end vertex in turn; a run walks every vertex
// below the vertex count in component order and emits one item per vertex. The
// adjacency row scan of a run checks one neighbor bit per cycle, and a run waits while
// the result channel stalls. The pending vertices of a run sit in a small ring/stack memory.
module adjacency_matrix_graph_traversal_top
  import amgt_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int DATA_WIDTH   = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  amgt_in_if.sink               in_ch,
  amgt_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int NW = (CW > VCOUNT_W) ? CW : VCOUNT_W;

  function automatic logic [VW-1:0] wrap_inc(input logic [VW-1:0] p);
    if (p == VW'(MAX_VERTICES - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  state_t                  state_r, state_nxt;
  logic                    mode_r;
  logic [VCOUNT_W-1:0]     vcount_r;
  logic [VW-1:0]           a_r, a_nxt;
  logic [VW-1:0]           b_r, b_nxt;
  logic [CW-1:0]           i_r, i_nxt;
  logic [CW-1:0]           j_r, j_nxt;
  logic [CW-1:0]           emit_cnt_r, emit_cnt_nxt;
  logic [VW-1:0]           head_r, head_nxt;
  logic [VW-1:0]           tail_r, tail_nxt;
  logic [CW-1:0]           pcount_r, pcount_nxt;
  logic [MAX_VERTICES-1:0] seen_r, seen_nxt;
  logic [MAX_VERTICES-1:0] row_r, row_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [VW-1:0]           out_vertex_r, out_vertex_nxt;
  logic [DATA_WIDTH-1:0]   out_value_r, out_value_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [VW-1:0]           pend_mem [MAX_VERTICES];
  logic [VW-1:0]           pend_rd_r;
  logic                    pend_re;
  logic [VW-1:0]           pend_raddr;
  logic                    push_en;
  logic [VW-1:0]           push_v;

  logic [CW-1:0]           n_w;
  logic                    in_fire;
  logic                    out_free;

  store_ctl_t              st_ctl;
  logic [VW-1:0]           st_wr_addr;
  logic [MAX_VERTICES-1:0] st_row_wdata;
  logic [VW-1:0]           st_rd_addr;
  logic [MAX_VERTICES-1:0] st_rd_row;
  logic [DATA_WIDTH-1:0]   st_rd_data;

  amgt_graph_store #(
    .MAX_VERTICES (MAX_VERTICES),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (st_ctl),
    .wr_addr    (st_wr_addr),
    .row_wdata  (st_row_wdata),
    .data_wdata (in_ch.vertex_value),
    .rd_addr    (st_rd_addr),
    .rd_row     (st_rd_row),
    .rd_data    (st_rd_data)
  );

  // Vertex count above the store size acts as the store size.
  always_comb begin
    if (NW'(vcount_r) > NW'(MAX_VERTICES)) begin
      n_w = CW'(MAX_VERTICES);
    end else begin
      n_w = CW'(vcount_r);
    end
  end

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign in_fire               = in_ch.valid && in_ch.ready;
  assign out_free              = !out_valid_r || out_ch.ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.visited_vertex = out_vertex_r;
  assign out_ch.visited_value  = out_value_r;
  assign out_ch.last_visit     = out_last_r;

  always_comb begin
    state_nxt      = state_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    emit_cnt_nxt   = emit_cnt_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    pcount_nxt     = pcount_r;
    seen_nxt       = seen_r;
    row_nxt        = row_r;
    out_vertex_nxt = out_vertex_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = (out_valid_r && out_ch.ready) ? 1'b0 : out_valid_r;
    st_ctl         = '0;
    st_wr_addr     = in_ch.first_vertex;
    st_row_wdata   = st_rd_row;
    st_rd_addr     = pend_rd_r;
    pend_re        = 1'b0;
    pend_raddr     = (mode_r == MODE_BFS) ? head_r : VW'(pcount_r - 1'b1);
    push_en        = 1'b0;
    push_v         = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          a_nxt = in_ch.first_vertex;
          b_nxt = in_ch.second_vertex;
          unique case (cmd_t'(in_ch.cmd))
            CMD_CLEAR: begin
              st_ctl.clear = 1'b1;
            end
            CMD_ADD_EDGE: begin
              if (int'(in_ch.first_vertex) < MAX_VERTICES &&
                  int'(in_ch.second_vertex) < MAX_VERTICES) begin
                state_nxt = ST_EDGE_RDA;
              end
            end
            CMD_SET_DATA: begin
              st_ctl.data_we = (int'(in_ch.first_vertex) < MAX_VERTICES);
            end
            CMD_RUN: begin
              seen_nxt     = '0;
              head_nxt     = '0;
              tail_nxt     = '0;
              pcount_nxt   = '0;
              i_nxt        = '0;
              emit_cnt_nxt = '0;
              state_nxt    = ST_RUN_NEXT;
            end
            default: ;
          endcase
        end
      end
      ST_EDGE_RDA: begin
        st_rd_addr = a_r;
        state_nxt  = ST_EDGE_WRA;
      end
      ST_EDGE_WRA: begin
        st_wr_addr    = a_r;
        st_row_wdata  = st_rd_row | (MAX_VERTICES'(1) << b_r);
        st_ctl.row_we = 1'b1;
        state_nxt     = ST_EDGE_RDB;
      end
      ST_EDGE_RDB: begin
        st_rd_addr = b_r;
        state_nxt  = ST_EDGE_WRB;
      end
      ST_EDGE_WRB: begin
        st_wr_addr    = b_r;
        st_row_wdata  = st_rd_row | (MAX_VERTICES'(1) << a_r);
        st_ctl.row_we = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_RUN_NEXT: begin
        // Start a new component at the next unvisited vertex.
        if (i_r == n_w) begin
          state_nxt = ST_IDLE;
        end else if (seen_r[i_r[VW-1:0]]) begin
          i_nxt = i_r + 1'b1;
        end else begin
          seen_nxt[i_r[VW-1:0]] = 1'b1;
          push_en   = 1'b1;
          push_v    = i_r[VW-1:0];
          state_nxt = ST_POP;
        end
      end
      ST_POP: begin
        if (pcount_r == '0) begin
          state_nxt = ST_RUN_NEXT;
        end else begin
          pend_re    = 1'b1;
          pcount_nxt = pcount_r - 1'b1;
          if (mode_r == MODE_BFS) begin
            head_nxt = wrap_inc(head_r);
          end
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // Hold until the output register is free.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_vertex_nxt = pend_rd_r;
          out_value_nxt  = st_rd_data;
          out_last_nxt   = (emit_cnt_r == n_w - 1'b1);
          emit_cnt_nxt   = emit_cnt_r + 1'b1;
          row_nxt        = st_rd_row;
          j_nxt          = '0;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (j_r == n_w) begin
          state_nxt = ST_POP;
        end else begin
          if (row_r[j_r[VW-1:0]] && !seen_r[j_r[VW-1:0]]) begin
            seen_nxt[j_r[VW-1:0]] = 1'b1;
            push_en = 1'b1;
            push_v  = j_r[VW-1:0];
          end
          j_nxt = j_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (push_en) begin
      pcount_nxt = pcount_r + 1'b1;
      if (mode_r == MODE_BFS) begin
        tail_nxt = wrap_inc(tail_r);
      end
    end
  end

  // Pending vertex memory: push at the tail (queue) or the top (stack).
  always_ff @(posedge clk) begin
    if (push_en) begin
      pend_mem[(mode_r == MODE_BFS) ? tail_r : pcount_r[VW-1:0]] <= push_v;
    end
    if (pend_re) begin
      pend_rd_r <= pend_mem[pend_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_BFS;
      vcount_r    <= VCOUNT_RST;
      i_r         <= '0;
      j_r         <= '0;
      emit_cnt_r  <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      pcount_r    <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      pcount_r    <= pcount_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_MODE:   mode_r   <= cfg_wdata[0];
          REG_VCOUNT: vcount_r <= cfg_wdata[VCOUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    row_r        <= row_nxt;
    out_vertex_r <= out_vertex_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

/* rtl/amgt_graph_store.sv */
// Adjacency row memory and vertex data memory with per-entry valid bits.
module amgt_graph_store
  import amgt_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int DATA_WIDTH   = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  store_ctl_t                   ctl,
  input  logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
  input  logic [MAX_VERTICES-1:0]      row_wdata,
  input  logic [DATA_WIDTH-1:0]        data_wdata,
  input  logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
  output logic [MAX_VERTICES-1:0]      rd_row,
  output logic [DATA_WIDTH-1:0]        rd_data
);

  logic [MAX_VERTICES-1:0] row_mem  [MAX_VERTICES];
  logic [DATA_WIDTH-1:0]   data_mem [MAX_VERTICES];

  logic [MAX_VERTICES-1:0] row_valid_r;
  logic [MAX_VERTICES-1:0] data_valid_r;
  logic                    row_ok_r;
  logic                    data_ok_r;
  logic [MAX_VERTICES-1:0] rd_row_r;
  logic [DATA_WIDTH-1:0]   rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.row_we) begin
      row_mem[wr_addr] <= row_wdata;
    end
    if (ctl.data_we) begin
      data_mem[wr_addr] <= data_wdata;
    end
    rd_row_r  <= row_mem[rd_addr];
    rd_data_r <= data_mem[rd_addr];
  end

  // An entry that was never written since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r  <= '0;
      data_valid_r <= '0;
      row_ok_r     <= 1'b0;
      data_ok_r    <= 1'b0;
    end else begin
      row_ok_r  <= row_valid_r[rd_addr];
      data_ok_r <= data_valid_r[rd_addr];
      if (ctl.clear) begin
        row_valid_r  <= '0;
        data_valid_r <= '0;
      end else begin
        if (ctl.row_we) begin
          row_valid_r[wr_addr] <= 1'b1;
        end
        if (ctl.data_we) begin
          data_valid_r[wr_addr] <= 1'b1;
        end
      end
    end
  end

  assign rd_row  = row_ok_r  ? rd_row_r  : '0;
  assign rd_data = data_ok_r ? rd_data_r : '0;

endmodule

/* bench/amgt_traversal_checker.sv */
// Visit-order predictor and result checker for the graph traversal block.
module amgt_traversal_checker
  import amgt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  amgt_in_if                    in_mon,
  amgt_out_if                   out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    visits_due
);

  typedef enum logic [1:0] {
    VISIT_NONE,
    VISIT_WAITING,
    VISIT_SEEN
  } visit_mark_t;

  typedef struct packed {
    logic [3:0]         vertex;
    logic signed [31:0] value;
    logic               last;
  } visit_t;

  logic [15:0]        adj_row [16];
  logic signed [31:0] vtx_word [16];
  visit_mark_t        mark [16];
  logic [3:0]         frontier [16];
  int unsigned        front_head;
  int unsigned        front_tail;
  int unsigned        front_size;
  logic               walk_dfs;
  logic [4:0]         vtx_limit;
  visit_t             expected_visits [$];

  // Ring queue in breadth-first mode, stack in depth-first mode.
  function automatic void frontier_push(input logic [3:0] v);
    if (front_size >= 16) return;
    if (walk_dfs == MODE_BFS) begin
      frontier[front_tail] = v;
      front_tail = (front_tail + 1) % 16;
    end else begin
      frontier[front_size] = v;
    end
    front_size++;
  endfunction

  function automatic logic [3:0] frontier_pop();
    logic [3:0] v;
    if (walk_dfs == MODE_BFS) begin
      v = frontier[front_head];
      front_head = (front_head + 1) % 16;
    end else begin
      v = frontier[front_size - 1];
    end
    front_size--;
    return v;
  endfunction

  function automatic void predict_walk();
    int         n;
    int         produced;
    logic [3:0] x;
    visit_t     r;
    n = (vtx_limit > 16) ? 16 : int'(vtx_limit);
    foreach (mark[i]) mark[i] = VISIT_NONE;
    front_head = 0;
    front_tail = 0;
    front_size = 0;
    produced = 0;
    for (int i = 0; i < n; i++) begin
      if (mark[i] == VISIT_NONE) begin
        mark[i] = VISIT_WAITING;
        frontier_push(i[3:0]);
      end
      while (front_size > 0) begin
        x = frontier_pop();
        mark[x] = VISIT_SEEN;
        r.vertex = x;
        r.value = vtx_word[x];
        r.last = 1'b0;
        expected_visits.push_back(r);
        produced++;
        // Mark neighbors as they enter the frontier, not when taken out.
        for (int j = 0; j < n; j++) begin
          if (adj_row[x][j] && mark[j] == VISIT_NONE) begin
            mark[j] = VISIT_WAITING;
            frontier_push(j[3:0]);
          end
        end
      end
    end
    if (produced > 0) begin
      r = expected_visits.pop_back();
      r.last = 1'b1;
      expected_visits.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    visit_t e;
    if (!rst_n) begin
      foreach (adj_row[i]) adj_row[i] = '0;
      foreach (vtx_word[i]) vtx_word[i] = '0;
      foreach (mark[i]) mark[i] = VISIT_NONE;
      front_head = 0;
      front_tail = 0;
      front_size = 0;
      walk_dfs = MODE_BFS;
      vtx_limit = VCOUNT_RST;
      expected_visits.delete();
      fail_count = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_visits.size() == 0) begin
          $display("%0t: ERROR unexpected visit: expected none, got vertex %0d value %0d last %0b",
                   $time, out_mon.visited_vertex, out_mon.visited_value, out_mon.last_visit);
          fail_count++;
        end else begin
          e = expected_visits.pop_front();
          if (out_mon.visited_vertex !== e.vertex) begin
            $display("%0t: ERROR visited_vertex: expected %0d, got %0d",
                     $time, e.vertex, out_mon.visited_vertex);
            fail_count++;
          end
          if (out_mon.visited_value !== e.value) begin
            $display("%0t: ERROR visited_value of vertex %0d: expected %0d, got %0d",
                     $time, e.vertex, e.value, out_mon.visited_value);
            fail_count++;
          end
          if (out_mon.last_visit !== e.last) begin
            $display("%0t: ERROR last_visit of vertex %0d: expected %0b, got %0b",
                     $time, e.vertex, e.last, out_mon.last_visit);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_MODE:   walk_dfs = cfg_wdata[0];
          REG_VCOUNT: vtx_limit = cfg_wdata[VCOUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.cmd)
          CMD_CLEAR: begin
            foreach (adj_row[i]) adj_row[i] = '0;
            foreach (vtx_word[i]) vtx_word[i] = '0;
          end
          CMD_ADD_EDGE: begin
            adj_row[in_mon.first_vertex][in_mon.second_vertex] = 1'b1;
            adj_row[in_mon.second_vertex][in_mon.first_vertex] = 1'b1;
          end
          CMD_SET_DATA: vtx_word[in_mon.first_vertex] = in_mon.vertex_value;
          CMD_RUN:      predict_walk();
          default: ;
        endcase
      end
    end
    visits_due = expected_visits.size();
  end

endmodule

/* bench/adjacency_matrix_graph_traversal_top_tb.sv */
// Stimulus, handshake pacing and verdict for the graph traversal block.
module adjacency_matrix_graph_traversal_top_tb;
  import amgt_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    visits_due;
  int                    burst_left;
  int                    items_sent;
  int                    cur_lim;
  bit                    long_hold_req;

  amgt_in_if  in_ch ();
  amgt_out_if out_ch ();

  adjacency_matrix_graph_traversal_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  amgt_traversal_checker visit_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .visits_due (visits_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: random stall patterns, plus one long hold-off on request.
  initial begin
    int mode_left;
    int stall_mode;
    out_ch.ready = 1'b0;
    mode_left = 0;
    stall_mode = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (600) @(negedge clk);
        long_hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        // 0: always ready, 1: light stalls, 2: heavy stalls, 3: periodic stall
        case (stall_mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          2:       out_ch.ready <= ($urandom_range(0, 9) < 3);
          default: out_ch.ready <= ((mode_left % 5) != 0);
        endcase
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input cmd_t c, input logic [3:0] a, input logic [3:0] b,
                           input logic [31:0] v);
    if (burst_left <= 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= c;
    in_ch.first_vertex <= a;
    in_ch.second_vertex <= b;
    in_ch.vertex_value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (visits_due != 0) @(negedge clk);
  endtask

  // Reconfigure only when idle: drain results, then let a whole run's worth of cycles pass.
  task automatic set_config(input logic mode, input logic [4:0] count);
    wait_drain();
    repeat (400) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= REG_MODE;
    cfg_wdata <= {4'd0, mode};
    @(negedge clk);
    cfg_idx <= REG_VCOUNT;
    cfg_wdata <= count;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_lim = (count > 16) ? 16 : int'(count);
  endtask

  // Mostly vertices in use, now and then one above the count.
  function automatic logic [3:0] pick_vertex();
    if (cur_lim == 0 || $urandom_range(0, 3) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, cur_lim - 1));
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [4:0] count_plan [8];
    int         phase;
    int         phase_start;
    bit         drained_once;
    count_plan = '{5'd16, 5'd1, 5'd2, 5'd31, 5'd16, 5'd7, 5'd16, 5'd11};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_CLEAR;
    in_ch.first_vertex = '0;
    in_ch.second_vertex = '0;
    in_ch.vertex_value = '0;
    long_hold_req = 1'b0;
    burst_left = 0;
    items_sent = 0;
    cur_lim = 16;
    drained_once = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty graph, data extremes, self loop, hidden vertices, count edges.
    send_item(CMD_RUN, 4'd0, 4'd0, 32'd0);
    send_item(CMD_SET_DATA, 4'd0, 4'd15, 32'h7FFF_FFFF);
    send_item(CMD_SET_DATA, 4'd15, 4'd0, 32'h8000_0000);
    send_item(CMD_SET_DATA, 4'd6, 4'd9, 32'hFFFF_FFFF);
    send_item(CMD_ADD_EDGE, 4'd0, 4'd15, 32'hFFFF_FFFF);
    send_item(CMD_ADD_EDGE, 4'd15, 4'd15, 32'd0);
    send_item(CMD_ADD_EDGE, 4'd15, 4'd6, 32'd0);
    send_item(CMD_ADD_EDGE, 4'd0, 4'd3, 32'd0);
    send_item(CMD_ADD_EDGE, 4'd3, 4'd9, 32'd0);
    send_item(CMD_ADD_EDGE, 4'd2, 4'd9, 32'd0);
    send_item(CMD_RUN, 4'd15, 4'd15, 32'hFFFF_FFFF);
    set_config(MODE_DFS, 5'd16);
    send_item(CMD_RUN, 4'd0, 4'd0, 32'd0);
    set_config(MODE_DFS, 5'd4);
    send_item(CMD_RUN, 4'd0, 4'd0, 32'd0);
    set_config(MODE_BFS, 5'd0);
    send_item(CMD_RUN, 4'd0, 4'd0, 32'd0);
    set_config(MODE_BFS, 5'd31);
    send_item(CMD_RUN, 4'd0, 4'd0, 32'd0);
    send_item(CMD_CLEAR, 4'd15, 4'd15, 32'hFFFF_FFFF);
    send_item(CMD_RUN, 4'd0, 4'd0, 32'd0);
    set_config(MODE_DFS, 5'd1);
    send_item(CMD_ADD_EDGE, 4'd0, 4'd0, 32'd0);
    send_item(CMD_SET_DATA, 4'd0, 4'd0, 32'h1234_5678);
    send_item(CMD_RUN, 4'd0, 4'd0, 32'd0);

    // Random: per phase one setting, then build-and-walk rounds with some noise.
    phase = 0;
    while (items_sent < 330) begin
      set_config(phase[0], (phase < 8) ? count_plan[phase] : 5'($urandom_range(1, 16)));
      // Starve the result side while runs keep coming.
      if (phase == 4) long_hold_req = 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < 40) begin
        if (phase == 3 && !drained_once && items_sent - phase_start >= 20) begin
          wait_drain();
          drained_once = 1'b1;
        end
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 4))
            send_item(cmd_t'($urandom_range(0, 3)), 4'($urandom), 4'($urandom), pick_word());
        end else begin
          if ($urandom_range(0, 4) == 0)
            send_item(CMD_CLEAR, 4'($urandom), 4'($urandom), $urandom);
          repeat ($urandom_range(0, 4))
            send_item(CMD_SET_DATA, pick_vertex(), 4'($urandom), pick_word());
          repeat ($urandom_range(0, 8))
            send_item(CMD_ADD_EDGE, pick_vertex(), pick_vertex(), $urandom);
          repeat ($urandom_range(1, 2))
            send_item(CMD_RUN, 4'($urandom), 4'($urandom), $urandom);
        end
      end
      phase++;
    end

    wait_drain();
    repeat (400) @(negedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
